>>> sv/gfre_pkg.sv
// Types, constant tables and encoding functions for the GFSK parameter encoder.
`default_nettype none
package gfre_pkg;

  localparam int unsigned RateRows = 13;
  localparam int unsigned ModRows  = 16;
  localparam int unsigned HzW      = 22;
  localparam int unsigned NumW     = 7;
  localparam int unsigned ProdW    = HzW + NumW;
  localparam int unsigned LimitW   = HzW + 6;
  localparam int unsigned DevScale = 40;

  localparam logic [7:0] SyncMatchWord1 = 8'h10;
  localparam logic [5:0] ShapeOff   = 6'h00;
  localparam logic [5:0] ShapeBt10  = 6'h10;
  localparam logic [5:0] ShapeBt05  = 6'h20;
  localparam logic [5:0] CrcOff     = 6'h00;
  localparam logic [5:0] CrcOneB    = 6'h10;
  localparam logic [5:0] CrcTwoB    = 6'h20;
  localparam logic [5:0] CrcThreeB  = 6'h30;
  localparam logic [3:0] WhiteOn    = 4'h0;
  localparam logic [3:0] WhiteOff   = 4'h8;
  localparam logic [6:0] PreambleMax = 7'h70;

  localparam logic [1:0] ModeShapeBt10 = 2'd1;
  localparam logic [1:0] ModeShapeBt05 = 2'd2;
  localparam logic [2:0] ModeCrcOneB   = 3'd1;
  localparam logic [2:0] ModeCrcTwoB   = 3'd2;
  localparam logic [2:0] ModeCrcIbm    = 3'd3;
  localparam logic [2:0] ModeCrcCcitt  = 3'd4;
  localparam logic [2:0] ModeCrcThreeB = 3'd5;

  localparam logic [HzW-1:0] RateTab [RateRows] = '{
    22'd125000, 22'd250000, 22'd250000, 22'd400000, 22'd500000, 22'd400000,
    22'd500000, 22'd800000, 22'd1000000, 22'd800000, 22'd1000000,
    22'd1600000, 22'd2000000
  };
  localparam logic [HzW-1:0] BwTab [RateRows] = '{
    22'd300000, 22'd300000, 22'd600000, 22'd600000, 22'd600000, 22'd1200000,
    22'd1200000, 22'd1200000, 22'd1200000, 22'd2400000, 22'd2400000,
    22'd2400000, 22'd2400000
  };
  localparam logic [7:0] RateBwCodeTab [RateRows] = '{
    8'hEF, 8'hC7, 8'hCE, 8'hAA, 8'h86, 8'hB1, 8'h8D,
    8'h69, 8'h45, 8'h70, 8'h4C, 8'h28, 8'h04
  };
  localparam logic [NumW-1:0] ModNumTab [ModRows] = '{
    7'd7, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40,
    7'd45, 7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80
  };

  typedef struct packed {
    logic [21:0] bit_rate;
    logic [21:0] bandwidth_hz;
    logic [21:0] freq_deviation;
    logic [1:0]  shaping_mode;
    logic [15:0] preamble_bits;
    logic [7:0]  sync_word_bits;
    logic [7:0]  header_kind;
    logic [7:0]  payload_len;
    logic [2:0]  crc_mode;
    logic        whitening_mode;
  } item_t;

  typedef struct packed {
    logic [7:0] rate_bw_code;
    logic [3:0] mod_index_code;
    logic [5:0] shaping_code;
    logic [6:0] preamble_code;
    logic [3:0] sync_len_code;
    logic [7:0] sync_match_code;
    logic [7:0] header_out;
    logic [7:0] payload_out;
    logic [5:0] crc_code;
    logic [3:0] whitening_code;
  } result_t;

  function automatic logic [6:0] enc_preamble(input logic [15:0] bits);
    logic [15:0] quads;
    logic [2:0]  code;
    quads = (bits + 16'd3) >> 2;
    code  = 3'(quads - 16'd1);
    if (bits <= 16'd4) begin
      enc_preamble = 7'h00;
    end else if (bits >= 16'd32) begin
      enc_preamble = PreambleMax;
    end else begin
      enc_preamble = {code, 4'h0};
    end
  endfunction

  function automatic logic [3:0] enc_sync_len(input logic [7:0] bits);
    logic [4:0] bytes;
    bytes = bits[7:3];
    if (bytes < 5'd1) begin
      bytes = 5'd1;
    end else if (bytes > 5'd5) begin
      bytes = 5'd5;
    end
    enc_sync_len = {bytes[2:0] - 3'd1, 1'b0};
  endfunction

  function automatic logic [5:0] enc_crc(input logic [2:0] mode);
    case (mode)
      ModeCrcOneB:                         enc_crc = CrcOneB;
      ModeCrcTwoB, ModeCrcIbm, ModeCrcCcitt: enc_crc = CrcTwoB;
      ModeCrcThreeB:                       enc_crc = CrcThreeB;
      default:                             enc_crc = CrcOff;
    endcase
  endfunction

  function automatic logic [5:0] enc_shaping(input logic [1:0] mode);
    case (mode)
      ModeShapeBt10: enc_shaping = ShapeBt10;
      ModeShapeBt05: enc_shaping = ShapeBt05;
      default:       enc_shaping = ShapeOff;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/gfsk_radio_param_encoder.sv
// Top level of the GFSK parameter encoder: three-stage table lookup pipeline.
`default_nettype none
// A new parameter set may be started in every clock cycle; its command bytes
// appear on result with done high once through the stage one, stage two and output registers.
// Stage one forms the scaled deviation limit, the sixteen rate products and
// the rate/bandwidth table compares; stage two compares the products with
// the limit and resolves the rate/bandwidth row; stage three resolves the
// modulation index row into the output register. Results are held for one
// cycle only, since the receiver cannot stall; busy is high only in reset.
module gfsk_radio_param_encoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  gfre_pkg::item_t  item,
  output logic             done,
  output gfre_pkg::result_t result
);
  import gfre_pkg::*;

  logic                accept;

  logic                s1_valid;
  logic [ProdW-1:0]    s1_prod [ModRows];
  logic [LimitW-1:0]   s1_limit;
  logic                s1_rate_zero;
  logic [RateRows-1:0] s1_hit;
  result_t             s1_res;

  logic                s2_valid;
  logic [ModRows-1:0]  s2_mod_ok;
  logic                s2_rate_zero;
  result_t             s2_res;

  logic [RateRows-1:0] hit_next;
  logic [LimitW-1:0]   limit_next;
  logic [ModRows-1:0]  mod_ok_next;
  logic [7:0]          rate_bw_next;
  logic [3:0]          mod_index_next;
  result_t             res1_next;
  result_t             res2_next;
  result_t             res3_next;

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    for (int i = 0; i < RateRows; i++) begin
      hit_next[i] = (item.bit_rate <= RateTab[i]) && (item.bandwidth_hz <= BwTab[i]);
    end
    // 40 * deviation as 32x + 8x.
    limit_next = (LimitW'(item.freq_deviation) << 5) + (LimitW'(item.freq_deviation) << 3);
    res1_next                 = '0;
    res1_next.shaping_code    = enc_shaping(item.shaping_mode);
    res1_next.preamble_code   = enc_preamble(item.preamble_bits);
    res1_next.sync_len_code   = enc_sync_len(item.sync_word_bits);
    res1_next.sync_match_code = SyncMatchWord1;
    res1_next.header_out      = item.header_kind;
    res1_next.payload_out     = item.payload_len;
    res1_next.crc_code        = enc_crc(item.crc_mode);
    res1_next.whitening_code  = item.whitening_mode ? WhiteOn : WhiteOff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    for (int k = 0; k < ModRows; k++) begin
      s1_prod[k] <= ProdW'(item.bit_rate) * ProdW'(ModNumTab[k]);
    end
    s1_limit     <= limit_next;
    s1_rate_zero <= (item.bit_rate == '0);
    s1_hit       <= hit_next;
    s1_res       <= res1_next;
  end

  always_comb begin
    for (int k = 0; k < ModRows; k++) begin
      mod_ok_next[k] = (s1_prod[k] <= ProdW'(s1_limit));
    end
    // The first matching row wins; no match falls back to the last row.
    rate_bw_next = RateBwCodeTab[RateRows-1];
    for (int i = RateRows - 1; i >= 0; i--) begin
      if (s1_hit[i]) begin
        rate_bw_next = RateBwCodeTab[i];
      end
    end
    res2_next              = s1_res;
    res2_next.rate_bw_code = rate_bw_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_mod_ok    <= mod_ok_next;
    s2_rate_zero <= s1_rate_zero;
    s2_res       <= res2_next;
  end

  always_comb begin
    // The largest passing row wins; a zero rate passes everything, so it is
    // forced to row zero.
    mod_index_next = '0;
    for (int k = 0; k < ModRows; k++) begin
      if (s2_mod_ok[k]) begin
        mod_index_next = 4'(k);
      end
    end
    if (s2_rate_zero) begin
      mod_index_next = '0;
    end
    res3_next                = s2_res;
    res3_next.mod_index_code = mod_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    result <= res3_next;
  end

endmodule
`default_nettype wire

>>> sv/gfre_checker.sv
// Port-level checker for the GFSK parameter encoder, bound to the top level.
`default_nettype none
module gfre_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input gfre_pkg::item_t   item,
  input logic              done,
  input gfre_pkg::result_t result
);
  import gfre_pkg::*;

  // Every transfer yields its result with done high once through the s1, s2 and output registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching transfer");

  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    (done && $past(item.bit_rate, 3) == '0) |-> (result.mod_index_code == '0))
    else $error("zero bit rate gave a non-zero modulation index");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.header_out == $past(item.header_kind, 3)
              && result.payload_out == $past(item.payload_len, 3)))
    else $error("header or payload byte not carried through");

  a_busy_reset: assert property (@(posedge clk)
    busy |-> rst)
    else $error("busy raised outside reset");

endmodule

bind gfsk_radio_param_encoder gfre_checker u_gfre_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
`default_nettype wire
